FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");
`endif

FILE: rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// S-box table, field doubling and byte selection used by the round datapath.
// ----------------------------------------------------------------------------
package aes_pkg;
  localparam int NumRounds = 10;
  localparam int RoundW = 4;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return tab[x];
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte n of a 128-bit block sits at bits 127-8n downto 120-8n.
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int n);
    return s[127 - 8 * n -: 8];
  endfunction
endpackage

FILE: rtl/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Iterative AES-128 encryption core with on-the-fly key schedule.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with key_hi, key_lo, plain_hi, plain_lo.
// Output channel: out_valid/out_ready with cipher_hi, cipher_lo.
// On acceptance the initial AddRoundKey is applied; one shared round unit
// then runs ten rounds, one per cycle, and the ciphertext is presented in
// the output register after the last round. The block takes one item at
// a time: in_ready is low from acceptance until the result is taken.
// When the receiver stalls, the result holds in the output register with
// out_valid high until taken. Synchronous reset drops any item in flight.
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] key_hi,
  input  logic [63:0] key_lo,
  input  logic [63:0] plain_hi,
  input  logic [63:0] plain_lo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] cipher_hi,
  output logic [63:0] cipher_lo
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]   st;
  logic [aes_pkg::RoundW-1:0] rnd;
  logic [7:0]   rcon;
  logic [127:0] state, rkey, state_nx, key_nx;

  aes_round u_round (
    .state_in (state),
    .key_in   (rkey),
    .rcon     (rcon),
    .last     (rnd == aes_pkg::RoundW'(aes_pkg::NumRounds)),
    .state_out(state_nx),
    .key_out  (key_nx)
  );

  assign in_ready  = (st == StIdle);
  assign out_valid = (st == StDone);
  assign cipher_hi = state[127:64];
  assign cipher_lo = state[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StIdle;
      rnd <= '0;
      rcon <= 8'h01;
    end else begin
      unique case (st)
        StIdle: begin
          if (in_valid) begin
            state <= {plain_hi, plain_lo} ^ {key_hi, key_lo};
            rkey <= {key_hi, key_lo};
            rnd <= aes_pkg::RoundW'(1);
            rcon <= 8'h01;
            st <= StRun;
          end
        end
        StRun: begin
          state <= state_nx;
          rkey <= key_nx;
          rcon <= aes_pkg::gf_dbl(rcon);
          rnd <= rnd + 1'b1;
          if (rnd == aes_pkg::RoundW'(aes_pkg::NumRounds)) begin
            st <= StDone;
          end
        end
        StDone: begin
          if (out_ready) begin
            st <= StIdle;
          end
        end
        default: st <= StIdle;
      endcase
    end
  end
endmodule

FILE: rtl/aes_round.sv
// ----------------------------------------------------------------------------
// AES round unit
// One round of state and key schedule per call, shared over all rounds.
// ----------------------------------------------------------------------------
module aes_round (
  input  logic [127:0] state_in,
  input  logic [127:0] key_in,
  input  logic [7:0]   rcon,
  input  logic         last,
  output logic [127:0] state_out,
  output logic [127:0] key_out
);
  logic [127:0] ss;
  logic [127:0] mc;
  logic [31:0]  t;
  logic [31:0]  w0, w1, w2, w3;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[127 - 8 * (4 * c + r) -: 8] =
          aes_pkg::sbox(aes_pkg::byte_at(state_in, 4 * ((c + r) % 4) + r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = aes_pkg::byte_at(ss, 4 * c);
      a1 = aes_pkg::byte_at(ss, 4 * c + 1);
      a2 = aes_pkg::byte_at(ss, 4 * c + 2);
      a3 = aes_pkg::byte_at(ss, 4 * c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32 * c -: 8]      = a0 ^ al ^ aes_pkg::gf_dbl(a0 ^ a1);
      mc[127 - 32 * c - 8 -: 8]  = a1 ^ al ^ aes_pkg::gf_dbl(a1 ^ a2);
      mc[127 - 32 * c - 16 -: 8] = a2 ^ al ^ aes_pkg::gf_dbl(a2 ^ a3);
      mc[127 - 32 * c - 24 -: 8] = a3 ^ al ^ aes_pkg::gf_dbl(a3 ^ a0);
    end
  end

  assign t = {aes_pkg::sbox(key_in[23:16]), aes_pkg::sbox(key_in[15:8]),
              aes_pkg::sbox(key_in[7:0]), aes_pkg::sbox(key_in[31:24])}
             ^ {rcon, 24'h0};
  assign w0 = key_in[127:96] ^ t;
  assign w1 = key_in[95:64] ^ w0;
  assign w2 = key_in[63:32] ^ w1;
  assign w3 = key_in[31:0] ^ w2;
  assign key_out = {w0, w1, w2, w3};
  assign state_out = (last ? ss : mc) ^ key_out;
endmodule

FILE: rtl/aes128_block_encrypt_chk.sv
// ----------------------------------------------------------------------------
// AES-128 port checker
// Port-level checks on the encrypt core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module aes128_block_encrypt_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] cipher_hi
);
  `CHK_IMPLY(no_overlap, clk, rst, out_valid, !in_ready)
  `CHK_NEXT(busy_after_accept, clk, rst, in_valid && in_ready, !in_ready && !out_valid)
  `CHK_NEXT(result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(cipher_hi))
  `CHK_NEXT(ready_after_take, clk, rst, out_valid && out_ready, in_ready)
endmodule

bind aes128_block_encrypt aes128_block_encrypt_chk u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .cipher_hi(cipher_hi)
);

FILE: test/aes128_block_encrypt_tb.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Sends key and plaintext items through the valid/ready input and compares
// every ciphertext item with an in-bench AES-128 cipher computed per item.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [63:0] plain_hi;
  logic [63:0] plain_lo;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;

  logic [127:0] cipher_due[$];
  int           mismatches;
  int           blocks_sent;
  int           blocks_checked;
  int           burst_left;

  aes128_block_encrypt dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {aes_pkg::sbox(w[31:24]), aes_pkg::sbox(w[23:16]),
            aes_pkg::sbox(w[15:8]), aes_pkg::sbox(w[7:0])};
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                               input logic [127:0] plain);
    logic [31:0]  w [44];
    logic [31:0]  t;
    logic [7:0]   rcon;
    logic [7:0]   s [16];
    logic [7:0]   u [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] res;
    rcon = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32 * i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i - 1];
      if (i % 4 == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = xtime(rcon);
      end
      w[i] = w[i - 4] ^ t;
    end
    for (int n = 0; n < 16; n++) s[n] = plain[127 - 8 * n -: 8] ^ w[n / 4][31 - 8 * (n % 4) -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) u[4 * c + r] = aes_pkg::sbox(s[4 * ((c + r) % 4) + r]);
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = u[4 * c]; a1 = u[4 * c + 1]; a2 = u[4 * c + 2]; a3 = u[4 * c + 3];
          all = a0 ^ a1 ^ a2 ^ a3;
          u[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
          u[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
          u[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
          u[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
      end
      for (int n = 0; n < 16; n++) s[n] = u[n] ^ w[4 * rnd + n / 4][31 - 8 * (n % 4) -: 8];
    end
    for (int n = 0; n < 16; n++) res[127 - 8 * n -: 8] = s[n];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = 64'h1 << $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  // The sender idles only between bursts; valid stays high within a burst.
  task automatic send_block(input logic [127:0] key, input logic [127:0] plain);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    {key_hi, key_lo} <= key;
    {plain_hi, plain_lo} <= plain;
    cipher_due.push_back(aes_encrypt(key, plain));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    blocks_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (cipher_due.size() == 0) begin
        $error("cipher item with no block outstanding");
        mismatches++;
      end else begin
        logic [127:0] exp;
        exp = cipher_due.pop_front();
        if (cipher_hi !== exp[127:64]) begin
          $error("cipher_hi expected %h actual %h", exp[127:64], cipher_hi);
          mismatches++;
        end
        if (cipher_lo !== exp[63:0]) begin
          $error("cipher_lo expected %h actual %h", exp[63:0], cipher_lo);
          mismatches++;
        end
        blocks_checked++;
      end
    end
  end

  // The receiver stalls at random on roughly a quarter of the cycles.
  always @(posedge clk) begin
    case ($urandom_range(0, 9))
      0, 1: out_ready <= 1'b0;
      2:    out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= 1'b1;
    endcase
  end

  task automatic test_known_vectors();
    send_block(128'h000102030405060708090a0b0c0d0e0f, 128'h00112233445566778899aabbccddeeff);
    send_block(128'h2b7e151628aed2a6abf7158809cf4f3c, 128'h3243f6a8885a308d313198a2e0370734);
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block('1, '0);
    send_block({2{64'haaaaaaaaaaaaaaaa}}, {2{64'h5555555555555555}});
    send_block({2{64'h5555555555555555}}, {2{64'haaaaaaaaaaaaaaaa}});
  endtask

  task automatic test_walking_bits();
    for (int i = 0; i < 128; i += 9) send_block(128'h1 << i, ~(128'h1 << (127 - i)));
  endtask

  task automatic test_random_blocks(input int count);
    for (int i = 0; i < count; i++)
      send_block({rand64(), rand64()}, {rand64(), rand64()});
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    key_hi = '0;
    key_lo = '0;
    plain_hi = '0;
    plain_lo = '0;
    out_ready = 1'b0;
    mismatches = 0;
    blocks_sent = 0;
    blocks_checked = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_vectors();
    test_walking_bits();
    test_random_blocks(1530);
    in_valid <= 1'b0;
    while (cipher_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Encrypted %0d blocks, checked %0d ciphertexts, with sender gaps and receiver stalls.",
             blocks_sent, blocks_checked);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_round.sv
rtl/aes128_block_encrypt.sv
rtl/aes128_block_encrypt_chk.sv
test/aes128_block_encrypt_tb.sv
